@@ rtl/fecf_pkg.sv @@
// Shared constants, beat and register types for the feedback echo comb filter.
`timescale 1ns / 1ps
`default_nettype none

package fecf_pkg;

  localparam int RING_DEPTH  = 131072;
  localparam int SAMPLE_BITS = 16;

  localparam int RING_AW = $clog2(RING_DEPTH);
  localparam int LEN_W   = RING_AW + 1;
  localparam int DELAY_W = 17;
  localparam int RLEN_W  = 18;
  localparam int GAIN_W  = 16;
  localparam int CMP_W   = (LEN_W > RLEN_W) ? LEN_W : RLEN_W;

  localparam int PROD_W = SAMPLE_BITS + GAIN_W + 2;
  localparam int FB_W   = SAMPLE_BITS + 1;
  localparam int SUM_W  = SAMPLE_BITS + 2;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

  // APB register map
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_DELAY = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_RLEN  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN  = 2'd2;

  localparam logic [DELAY_W-1:0] RST_DELAY = 17'd22050;
  localparam logic [RLEN_W-1:0]  RST_RLEN  = 18'd88200;
  localparam logic [GAIN_W-1:0]  RST_GAIN  = 16'd16384;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          block_end_in;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          block_end_out;
  } out_beat_t;

  typedef struct packed {
    logic [DELAY_W-1:0] delay_samples;
    logic [RLEN_W-1:0]  ring_length;
    logic [GAIN_W-1:0]  feedback_gain;
  } cfg_t;

endpackage

`default_nettype wire

@@ rtl/fecf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module fecf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/fecf_regs.sv @@
// APB configuration registers: delay, ring length and feedback gain.
`timescale 1ns / 1ps
`default_nettype none

module fecf_regs
  import fecf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire logic [REG_IDX_W-1:0] idx,
  input  wire logic [DATA_W-1:0]    wdata,
  output logic      [DATA_W-1:0]    rdata,
  output cfg_t                      cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_DELAY: cfg_nxt.delay_samples = wdata[DELAY_W-1:0];
        REG_RLEN:  cfg_nxt.ring_length   = wdata[RLEN_W-1:0];
        REG_GAIN:  cfg_nxt.feedback_gain = wdata[GAIN_W-1:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delay_samples <= RST_DELAY;
      cfg_r.ring_length   <= RST_RLEN;
      cfg_r.feedback_gain <= RST_GAIN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_DELAY: rdata = DATA_W'(cfg_r.delay_samples);
      REG_RLEN:  rdata = DATA_W'(cfg_r.ring_length);
      REG_GAIN:  rdata = DATA_W'(cfg_r.feedback_gain);
      default:   rdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ rtl/feedback_echo_comb_filter_unit.sv @@
// Feedback comb filter (echo) top level: ring address, feedback math, output register.
//
// Usage: one interleaved sample enters per in_ beat (valid/stall); one echoed,
// saturated sample leaves per out_ beat, in order, with block_end copied along.
// Channels are not told apart: the delay counts interleaved samples.
// Configuration goes through the APB port (0x0 delay, 0x4 ring length,
// 0x8 feedback gain); pready is tied high. Write registers only while idle.
// An accepted beat is held in the math stage register, then in the output
// register, where out_valid rises. Throughput: one beat per cycle while
// out_stall is low, set by the single read port and single write port of
// the ring RAM; the read of the next sample overlaps the write-back of the
// previous one, with a bypass when both hit the same entry.
// Stall: out_stall holds the output register; the input is stalled only when
// both the output register and the math stage are full.
// Reset: config returns to defaults, pointer to 0. The ring needs no clearing
// pass: writes always fill a prefix of the ring from entry 0, so a fill mark
// tells written entries from unwritten ones, which read as zero.
`timescale 1ns / 1ps
`default_nettype none

module feedback_echo_comb_filter_unit
  import fecf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_beat_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_beat_t              out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  cfg_t cfg;

  // ---------------- configuration ----------------
  assign pready = 1'b1;

  fecf_regs u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (psel & penable & pwrite),
    .idx   (paddr[ADDR_W-1:2]),
    .wdata (pwdata),
    .rdata (prdata),
    .cfg   (cfg)
  );

  // ---------------- handshake ----------------
  logic out_valid_r, out_valid_nxt;
  logic s1_vld_r, s1_vld_nxt;
  logic out_free, s1_fire, in_acc;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_vld_r && out_free;
  assign in_stall = s1_vld_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  // ---------------- address stage ----------------
  logic [CMP_W-1:0]   len_ext, d_ext;
  logic [LEN_W-1:0]   len_eff, wp_inc;
  logic [RING_AW-1:0] d_eff, wp_eff, rd_addr;
  logic [RING_AW-1:0] wp_r, wp_nxt;
  logic [LEN_W-1:0]   hwm_r, hwm_nxt, wa_inc;

  always_comb begin
    len_ext = CMP_W'(cfg.ring_length);
    priority if (len_ext > CMP_W'(RING_DEPTH)) begin
      len_eff = LEN_W'(RING_DEPTH);
    end else if (len_ext < CMP_W'(2)) begin
      len_eff = LEN_W'(2);
    end else begin
      len_eff = LEN_W'(len_ext);
    end

    d_ext = CMP_W'(cfg.delay_samples);
    if (d_ext >= CMP_W'(len_eff)) begin
      d_eff = RING_AW'(len_eff - LEN_W'(1));
    end else begin
      d_eff = RING_AW'(d_ext);
    end

    // pointer restarts when the ring was shortened under it
    wp_eff = (LEN_W'(wp_r) >= len_eff) ? '0 : wp_r;

    if (wp_eff >= d_eff) begin
      rd_addr = wp_eff - d_eff;
    end else begin
      rd_addr = RING_AW'(LEN_W'(wp_eff) + len_eff - LEN_W'(d_eff));
    end

    wp_inc = LEN_W'(wp_eff) + LEN_W'(1);
    wp_nxt = (wp_inc >= len_eff) ? '0 : RING_AW'(wp_inc);
  end

  // ---------------- math stage registers ----------------
  logic signed [SAMPLE_BITS-1:0] s1_x_r;
  logic                          s1_blk_r;
  logic [RING_AW-1:0]            s1_wa_r;
  logic                          s1_ok_r;
  logic                          s1_fwd_r;
  logic [SAMPLE_BITS-1:0]        s1_fwd_q_r;
  logic [SAMPLE_BITS-1:0]        ram_rdata;
  logic [SAMPLE_BITS-1:0]        sat_q;

  // ---------------- feedback math ----------------
  logic [SAMPLE_BITS-1:0]        echo;
  logic signed [SAMPLE_BITS:0]   echo_ext;
  logic signed [GAIN_W:0]        gain_ext;
  logic signed [PROD_W-1:0]      prod;
  logic signed [FB_W-1:0]        fb;
  logic signed [SUM_W-1:0]       sum;

  always_comb begin
    if (s1_fwd_r) begin
      echo = s1_fwd_q_r;
    end else if (s1_ok_r) begin
      echo = ram_rdata;
    end else begin
      echo = '0;
    end
    echo_ext = $signed({echo[SAMPLE_BITS-1], echo});
    gain_ext = $signed({1'b0, cfg.feedback_gain});
    prod     = echo_ext * gain_ext;
    // floor shift: arithmetic shift right drops the fraction toward -inf
    fb       = prod[GAIN_W +: FB_W];
    sum      = $signed({{(SUM_W - SAMPLE_BITS){s1_x_r[SAMPLE_BITS-1]}}, s1_x_r})
             + $signed({fb[FB_W-1], fb});
    priority if (sum > SAT_HI) begin
      sat_q = SAT_HI[SAMPLE_BITS-1:0];
    end else if (sum < SAT_LO) begin
      sat_q = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      sat_q = sum[SAMPLE_BITS-1:0];
    end
  end

  fecf_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_wa_r),
    .wdata (sat_q),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // fill mark: entries [0, hwm) have been written since reset
  always_comb begin
    wa_inc  = LEN_W'(s1_wa_r) + LEN_W'(1);
    hwm_nxt = hwm_r;
    if (s1_fire && (wa_inc > hwm_r)) begin
      hwm_nxt = wa_inc;
    end
  end

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_acc) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_vld_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      wp_r        <= '0;
      hwm_r       <= '0;
    end else begin
      s1_vld_r    <= s1_vld_nxt;
      out_valid_r <= out_valid_nxt;
      hwm_r       <= hwm_nxt;
      if (in_acc) begin
        wp_r <= wp_nxt;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_x_r     <= in_data.sample_in;
      s1_blk_r   <= in_data.block_end_in;
      s1_wa_r    <= wp_eff;
      s1_ok_r    <= LEN_W'(rd_addr) < hwm_r;
      // previous sample is written at this same edge: bypass the RAM
      s1_fwd_r   <= s1_fire && (rd_addr == s1_wa_r);
      s1_fwd_q_r <= sat_q;
    end
    if (s1_fire) begin
      out_data.sample_out    <= $signed(sat_q);
      out_data.block_end_out <= s1_blk_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ rtl/fecf_checker.sv @@
// Port-level checks for the feedback echo comb filter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module fecf_checker
  import fecf_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire out_beat_t         out_data
);

  logic       in_beat, out_beat;
  logic [2:0] cnt_r, cnt_nxt;

  assign in_beat  = in_valid && !in_stall;
  assign out_beat = out_valid && !out_stall;

  // beats accepted but not yet delivered
  always_comb begin
    cnt_nxt = cnt_r + 3'(in_beat) - 3'(out_beat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd2)
    else $error("more than two beats in flight");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != 3'd0)
    else $error("output beat without a matching input beat");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output side is free");

endmodule

bind feedback_echo_comb_filter_unit fecf_checker u_fecf_checker (.*);

`default_nettype wire
